// ===== src/rtit_pkg.sv =====
// ----------------------------------------------------------------------------
// rtit_pkg
// Types and constants shared by the record table cells, controller and top.
// ----------------------------------------------------------------------------
package rtit_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int POS_W    = 6;
	localparam int TOT_W    = 7;
	localparam int OP_W     = 2;
	localparam int STAT_W   = 3;

	typedef struct packed {
		logic [7:0]  phone_tail;
		logic [63:0] phone_head;
		logic [7:0]  surname_tail;
		logic [63:0] surname_head;
		logic [7:0]  first_name_tail;
		logic [63:0] first_name_head;
	} record_t;

	localparam int REC_W    = $bits(record_t);
	localparam int S_DATA_W = ((REC_W + 7) / 8) * 8;
	localparam int M_BITS   = POS_W + REC_W + TOT_W;
	localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE      = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_RECORD    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             rotate;
		logic             compact;
		logic             write;
		logic [IDX_W-1:0] sel_idx;
	} cell_ctl_t;

endpackage

// ===== src/rtit_cell.sv =====
// ----------------------------------------------------------------------------
// rtit_cell
// One table slot: rotates toward the head, shifts down on compaction, or
// takes the broadcast record when its index is selected for an append.
// ----------------------------------------------------------------------------
module rtit_cell (
	input  logic                    clk,
	input  rtit_pkg::cell_ctl_t     ctl,
	input  logic [rtit_pkg::IDX_W-1:0] index,
	input  rtit_pkg::record_t       nbr,
	input  rtit_pkg::record_t       wdata,
	output rtit_pkg::record_t       rec
);
	import rtit_pkg::*;

	record_t rec_q;

	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			rec_q <= nbr;
		end else if (ctl.compact && (index >= ctl.sel_idx)) begin
			rec_q <= nbr;
		end else if (ctl.write && (index == ctl.sel_idx)) begin
			rec_q <= wdata;
		end
	end

	assign rec = rec_q;

endmodule

// ===== src/rtit_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtit_ctrl
// Operation sequencer: decodes beats, walks the cell ring, holds one pending
// match so the final result can carry tlast, and drives the output register.
// ----------------------------------------------------------------------------
module rtit_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rtit_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [rtit_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rtit_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [rtit_pkg::STAT_W-1:0]    m_tuser,
	output logic                           m_tlast,
	input  rtit_pkg::record_t              head,
	output rtit_pkg::cell_ctl_t            cell_ctl,
	output rtit_pkg::record_t              wdata
);
	import rtit_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	op_t              op_q;
	record_t          key_q;
	logic [IDX_W-1:0] step_q;
	logic             pend_valid_q;
	record_t          pend_rec_q;
	logic [IDX_W-1:0] pend_pos_q;
	logic             found_q;
	logic [IDX_W-1:0] del_idx_q;

	logic             out_valid_q;
	status_t          out_stat_q;
	logic [POS_W-1:0] out_pos_q;
	record_t          out_rec_q;
	logic [TOT_W-1:0] out_tot_q;
	logic             out_last_q;

	logic             out_free, in_beat, table_empty, table_full, walk_start;
	logic             head_valid, name_hit, phone_hit, hit, adv, last_step;
	op_t              in_op;
	record_t          in_rec;

	logic             load;
	status_t          ld_stat;
	logic [POS_W-1:0] ld_pos;
	record_t          ld_rec;
	logic [TOT_W-1:0] ld_tot;
	logic             ld_last;
	logic             cnt_inc, cnt_dec;

	assign out_free    = !out_valid_q || m_tready;
	assign in_beat     = s_tvalid && s_tready;
	assign in_op       = op_t'(s_tuser);
	assign in_rec      = record_t'(s_tdata[REC_W-1:0]);
	assign table_empty = (count_q == '0);
	assign table_full  = (count_q >= CNT_W'(CAPACITY));
	assign walk_start  = in_beat && ((in_op == OP_SEARCH) ||
		(((in_op == OP_DELETE) || (in_op == OP_LIST)) && !table_empty));
	assign head_valid  = (CNT_W'(step_q) < count_q);
	assign name_hit    = (head.first_name_head == key_q.first_name_head) &&
		(head.first_name_tail == key_q.first_name_tail);
	assign phone_hit   = (head.phone_head == key_q.phone_head) &&
		(head.phone_tail == key_q.phone_tail);
	assign hit         = head_valid && ((op_q == OP_LIST) ||
		((op_q == OP_SEARCH) && name_hit));
	assign last_step   = (step_q == IDX_W'(CAPACITY - 1));
	assign wdata       = in_rec;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (walk_start) state_d = S_WALK;
			end
			S_WALK: begin
				if (out_free && last_step) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cell_ctl = '0;
		adv      = 1'b0;
		load     = 1'b0;
		ld_stat  = STAT_DONE;
		ld_pos   = '0;
		ld_rec   = '0;
		ld_tot   = TOT_W'(count_q);
		ld_last  = 1'b1;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = out_free;
				if (in_beat) begin
					case (in_op)
						OP_ADD: begin
							load = 1'b1;
							if (table_full) begin
								ld_stat = STAT_FULL;
							end else begin
								cell_ctl.write   = 1'b1;
								cell_ctl.sel_idx = count_q[IDX_W-1:0];
								cnt_inc          = 1'b1;
								ld_tot           = TOT_W'(count_q + CNT_W'(1));
							end
						end
						OP_DELETE, OP_LIST: begin
							if (table_empty) begin
								load    = 1'b1;
								ld_stat = STAT_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			S_WALK: begin
				if (out_free) begin
					adv             = 1'b1;
					cell_ctl.rotate = 1'b1;
					if (hit && pend_valid_q) begin
						load    = 1'b1;
						ld_stat = STAT_RECORD;
						ld_pos  = POS_W'(pend_pos_q);
						ld_rec  = pend_rec_q;
						ld_last = 1'b0;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					load = 1'b1;
					if (op_q == OP_DELETE) begin
						if (found_q) begin
							cell_ctl.compact = 1'b1;
							cell_ctl.sel_idx = del_idx_q;
							cnt_dec          = 1'b1;
							ld_tot           = TOT_W'(count_q - CNT_W'(1));
						end else begin
							ld_stat = STAT_NOT_FOUND;
						end
					end else if (pend_valid_q) begin
						ld_stat = STAT_RECORD;
						ld_pos  = POS_W'(pend_pos_q);
						ld_rec  = pend_rec_q;
					end else begin
						ld_stat = STAT_NOT_FOUND;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			pend_valid_q <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) count_q <= count_q + CNT_W'(1);
			else if (cnt_dec) count_q <= count_q - CNT_W'(1);
			if (walk_start) begin
				step_q       <= '0;
				pend_valid_q <= 1'b0;
				found_q      <= 1'b0;
			end else if (adv) begin
				step_q <= step_q + IDX_W'(1);
				if (hit) pend_valid_q <= 1'b1;
				if ((op_q == OP_DELETE) && head_valid && phone_hit) found_q <= 1'b1;
			end
			if (load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q  <= in_op;
			key_q <= in_rec;
		end
		if (adv && hit) begin
			pend_rec_q <= head;
			pend_pos_q <= step_q;
		end
		if (adv && (op_q == OP_DELETE) && head_valid && phone_hit && !found_q) begin
			del_idx_q <= step_q;
		end
		if (load) begin
			out_stat_q <= ld_stat;
			out_pos_q  <= ld_pos;
			out_rec_q  <= ld_rec;
			out_tot_q  <= ld_tot;
			out_last_q <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(M_DATA_W - M_BITS){1'b0}}, out_tot_q, out_rec_q, out_pos_q};

endmodule

// ===== src/record_table_insert_delete_search_top.sv =====
// ----------------------------------------------------------------------------
// record_table_insert_delete_search_top
// Record table of CAPACITY entries with add, delete, search and list.
// ----------------------------------------------------------------------------
// Add, and any operation refused on a full or empty table, answers with a
// single beat. Delete, search and list walk the ring of record cells, one
// cell per cycle while the output is not stalled, through all CAPACITY cells
// and then a finishing state; the next beat is taken only once the walk and
// the finishing state are over. Search sends one beat per matching record and
// list one beat per record, in table order, tlast on the final one, or a
// single not-found or empty beat. The table holds no clearing pass: entries
// are read only below the record count.
module record_table_insert_delete_search_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// first_name_head, first_name_tail, surname_head, surname_tail,
	// phone_head, phone_tail
	input  logic [rtit_pkg::S_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [rtit_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// position, first_name_head_res, first_name_tail_res, surname_head_res,
	// surname_tail_res, phone_head_res, phone_tail_res, entry_total, zero pad
	output logic [rtit_pkg::M_DATA_W-1:0]  m_tdata,
	// status
	output logic [rtit_pkg::STAT_W-1:0]    m_tuser,
	// last
	output logic                           m_tlast
);
	import rtit_pkg::*;

	cell_ctl_t cell_ctl;
	record_t   wdata;
	record_t   cells [CAPACITY];

	rtit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.head     (cells[0]),
		.cell_ctl (cell_ctl),
		.wdata    (wdata)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rtit_cell u_cell (
			.clk   (clk),
			.ctl   (cell_ctl),
			.index (IDX_W'(i)),
			.nbr   (cells[(i + 1) % CAPACITY]),
			.wdata (wdata),
			.rec   (cells[i])
		);
	end

endmodule

// ===== src/rtit_checker.sv =====
// ----------------------------------------------------------------------------
// rtit_checker
// Port-level checks on the record table result stream.
// ----------------------------------------------------------------------------
module rtit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [rtit_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [rtit_pkg::OP_W-1:0]      s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [rtit_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic [rtit_pkg::STAT_W-1:0]    m_tuser,
	input  logic                           m_tlast
);
	import rtit_pkg::*;

	logic unused_in;
	assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_RECORD) |-> m_tlast)
		else $error("status beat without tlast");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_RECORD) |-> (m_tdata[POS_W+REC_W-1:0] == '0))
		else $error("status beat carries record data");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_BITS-1:POS_W+REC_W] <= TOT_W'(CAPACITY)))
		else $error("entry total beyond capacity");

endmodule

bind record_table_insert_delete_search_top rtit_checker u_rtit_checker (.*);

// ===== verif/tb_record_table_insert_delete_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_table_insert_delete_search_top
// Self-checking bench for the record table: add, delete, search and list.
// Items go in as stream beats with random gaps. A table copy inside the bench
// predicts every reply beat. A checker compares each output beat field by
// field against the oldest pending reply. Phases: directed corner cases, a
// fill to capacity, a long output stall, then random traffic.
// ----------------------------------------------------------------------------
module tb_record_table_insert_delete_search_top;
	import rtit_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;

	typedef struct {
		status_t          status;
		logic [POS_W-1:0] position;
		record_t          rec;
		logic [TOT_W-1:0] total;
		logic             last;
	} table_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0]     s_tuser = OP_ADD;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]   m_tuser;
	logic                m_tlast;

	record_t      tbl_rec [CAPACITY];
	int           tbl_count = 0;
	table_reply_t replies_due [$];

	int  errors = 0;
	int  cycle_count = 0;
	bit  tx_quiet = 1'b0;
	bit  rx_quiet = 1'b0;
	int  rx_hold = 0;

	logic [63:0] name_head_pool [4];
	logic [7:0]  name_tail_pool [4];
	logic [63:0] phone_head_pool [4];
	logic [7:0]  phone_tail_pool [4];

	record_table_insert_delete_search_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int draw_gap(bit quiet);
		return quiet ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic record_t make_key(logic [63:0] fh, logic [7:0] ft, logic [63:0] sh,
			logic [7:0] st, logic [63:0] ph, logic [7:0] pt);
		record_t k;
		k.first_name_head = fh;
		k.first_name_tail = ft;
		k.surname_head    = sh;
		k.surname_tail    = st;
		k.phone_head      = ph;
		k.phone_tail      = pt;
		return k;
	endfunction

	function automatic record_t rand_key();
		record_t k;
		int      n;
		n = $urandom_range(0, 3);
		k = make_key(rand64(), 8'($urandom), rand64(), 8'($urandom), rand64(), 8'($urandom));
		if ($urandom_range(0, 4) != 0) begin
			k.first_name_head = name_head_pool[n];
			k.first_name_tail = name_tail_pool[n];
		end
		if ($urandom_range(0, 4) == 0) begin
			k.phone_head = phone_head_pool[n];
			k.phone_tail = phone_tail_pool[n];
		end
		if ($urandom_range(0, 3) == 0)
			k.surname_tail = 8'h00;
		return k;
	endfunction

	function automatic void push_reply(status_t st, int pos, record_t rec, logic lst);
		table_reply_t rp;
		rp.status   = st;
		rp.position = POS_W'(pos);
		rp.rec      = rec;
		rp.total    = TOT_W'(tbl_count);
		rp.last     = lst;
		replies_due.push_back(rp);
	endfunction

	// table copy: updates state and queues the reply beats of one item
	function automatic void predict_table(op_t op, record_t key);
		int hit;
		int last_j;
		hit = -1;
		last_j = -1;
		case (op)
			OP_ADD: begin
				if (tbl_count >= CAPACITY) begin
					push_reply(STAT_FULL, 0, '0, 1'b1);
				end else begin
					tbl_rec[tbl_count] = key;
					tbl_count++;
					push_reply(STAT_DONE, 0, '0, 1'b1);
				end
			end
			OP_DELETE: begin
				for (int j = 0; j < tbl_count; j++)
					if (hit < 0 && tbl_rec[j].phone_head == key.phone_head &&
							tbl_rec[j].phone_tail == key.phone_tail)
						hit = j;
				if (tbl_count == 0) begin
					push_reply(STAT_EMPTY, 0, '0, 1'b1);
				end else if (hit < 0) begin
					push_reply(STAT_NOT_FOUND, 0, '0, 1'b1);
				end else begin
					for (int k = hit; k + 1 < tbl_count; k++)
						tbl_rec[k] = tbl_rec[k + 1];
					tbl_count--;
					push_reply(STAT_DONE, 0, '0, 1'b1);
				end
			end
			default: begin
				for (int j = 0; j < tbl_count; j++)
					if (op == OP_LIST || (tbl_rec[j].first_name_head == key.first_name_head &&
							tbl_rec[j].first_name_tail == key.first_name_tail))
						last_j = j;
				if (op == OP_LIST && tbl_count == 0) begin
					push_reply(STAT_EMPTY, 0, '0, 1'b1);
				end else if (last_j < 0) begin
					push_reply(STAT_NOT_FOUND, 0, '0, 1'b1);
				end else begin
					for (int j = 0; j <= last_j; j++)
						if (op == OP_LIST || (tbl_rec[j].first_name_head == key.first_name_head &&
								tbl_rec[j].first_name_tail == key.first_name_tail))
							push_reply(STAT_RECORD, j, tbl_rec[j], j == last_j);
				end
			end
		endcase
	endfunction

	task automatic send_item(op_t op, record_t key);
		int gap;
		gap = draw_gap(tx_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
		predict_table(op, key);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 40)
			$display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// output side: random ready gaps, plus long holds on request
	initial begin : beat_sink
		int w;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w = draw_gap(rx_quiet) + rx_hold;
			rx_hold = 0;
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : beat_check
		table_reply_t rp;
		record_t      got_rec;
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("beat with no reply pending", 64'(m_tuser), 64'(0));
			end else begin
				rp = replies_due.pop_front();
				got_rec = m_tdata[POS_W +: REC_W];
				check_field("status", 64'(m_tuser), 64'(rp.status));
				check_field("position", 64'(m_tdata[POS_W-1:0]), 64'(rp.position));
				check_field("first_name_head", got_rec.first_name_head, rp.rec.first_name_head);
				check_field("first_name_tail", 64'(got_rec.first_name_tail),
					64'(rp.rec.first_name_tail));
				check_field("surname_head", got_rec.surname_head, rp.rec.surname_head);
				check_field("surname_tail", 64'(got_rec.surname_tail), 64'(rp.rec.surname_tail));
				check_field("phone_head", got_rec.phone_head, rp.rec.phone_head);
				check_field("phone_tail", 64'(got_rec.phone_tail), 64'(rp.rec.phone_tail));
				check_field("entry_total", 64'(m_tdata[POS_W+REC_W +: TOT_W]), 64'(rp.total));
				check_field("last", 64'(m_tlast), 64'(rp.last));
			end
		end
	end

	task automatic test_directed();
		record_t ones;
		record_t zero;
		record_t a1;
		record_t a2;
		ones = '1;
		zero = '0;
		a1 = make_key(name_head_pool[0], name_tail_pool[0], rand64(), 8'($urandom),
			phone_head_pool[1], phone_tail_pool[1]);
		a2 = make_key(name_head_pool[0], name_tail_pool[0], rand64(), 8'($urandom),
			phone_head_pool[2], phone_tail_pool[2]);
		// empty table
		send_item(OP_LIST, zero);
		send_item(OP_DELETE, zero);
		send_item(OP_SEARCH, zero);
		send_item(OP_ADD, zero);
		send_item(OP_ADD, ones);
		send_item(OP_ADD, a1);
		send_item(OP_ADD, a2);
		send_item(OP_SEARCH, ones);
		send_item(OP_SEARCH, a1);
		send_item(OP_SEARCH, zero);
		// keys that differ only in byte 8
		send_item(OP_SEARCH, make_key(a1.first_name_head, a1.first_name_tail ^ 8'h01,
			'0, '0, '0, '0));
		send_item(OP_DELETE, make_key('0, '0, '0, '0, a1.phone_head, a1.phone_tail ^ 8'h80));
		send_item(OP_DELETE, a1);
		send_item(OP_LIST, zero);
		send_item(OP_DELETE, zero);
		send_item(OP_LIST, zero);
		send_item(OP_DELETE, a2);
		send_item(OP_LIST, zero);
		send_item(OP_DELETE, ones);
		send_item(OP_LIST, ones);
		send_item(OP_SEARCH, ones);
	endtask

	task automatic test_full_table();
		record_t k;
		while (tbl_count < CAPACITY) begin
			k = rand_key();
			k.first_name_head = name_head_pool[0];
			k.first_name_tail = name_tail_pool[0];
			send_item(OP_ADD, k);
		end
		send_item(OP_ADD, rand_key());
		send_item(OP_SEARCH, tbl_rec[0]);
		send_item(OP_LIST, rand_key());
		send_item(OP_DELETE, tbl_rec[CAPACITY-1]);
		send_item(OP_DELETE, tbl_rec[0]);
		send_item(OP_ADD, rand_key());
		send_item(OP_ADD, rand_key());
		send_item(OP_ADD, rand_key());
		send_item(OP_LIST, rand_key());
	endtask

	task automatic test_output_stall();
		tx_quiet = 1'b1;
		rx_hold = 400;
		repeat (12) begin
			if ($urandom_range(0, 1) == 0)
				send_item(OP_SEARCH, rand_key());
			else
				send_item(OP_DELETE, tbl_count > 0 ? tbl_rec[$urandom_range(0, tbl_count-1)] :
					rand_key());
		end
		tx_quiet = 1'b0;
	endtask

	task automatic test_random_ops(int count);
		int      r;
		record_t k;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			k = rand_key();
			if (r < 38) begin
				send_item(OP_ADD, k);
			end else if (r < 68) begin
				if (tbl_count > 0 && $urandom_range(0, 3) != 0)
					k = tbl_rec[$urandom_range(0, tbl_count-1)];
				send_item(OP_DELETE, k);
			end else if (r < 90) begin
				if (tbl_count > 0 && $urandom_range(0, 1) == 0)
					k = tbl_rec[$urandom_range(0, tbl_count-1)];
				send_item(OP_SEARCH, k);
			end else begin
				send_item(OP_LIST, k);
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < 4; i++) begin
			name_head_pool[i]  = rand64();
			name_tail_pool[i]  = 8'($urandom);
			phone_head_pool[i] = rand64();
			phone_tail_pool[i] = 8'($urandom);
		end
		// short, zero-padded name
		name_head_pool[0] = 64'($urandom_range(1, 24'hFFFFFF));
		name_tail_pool[0] = 8'h00;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table();
		test_output_stall();
		test_random_ops(130);

		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (CAPACITY + 16) @(posedge clk);

		if (errors == 0 && replies_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
